### hdl/csta_pkg.sv
package csta_pkg;

  localparam int unsigned NumSlotsDefault = 8;

  localparam int unsigned IpW      = 32;
  localparam int unsigned PortW    = 16;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned OpW      = 2;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0] ReloadTicksReset = TimerW'(10);

  localparam logic [CfgIdxW-1:0] CfgReloadTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFwdEnable   = 1'b1;

  typedef enum logic [OpW-1:0] {
    OpPacket = 2'd0,
    OpTick   = 2'd1,
    OpDrop   = 2'd2
  } op_e;

  typedef enum logic [SlotW-1:0] {
    StIgnored = 3'd0,
    StKnown   = 3'd1,
    StAdded   = 3'd2,
    StFull    = 3'd3,
    StTick    = 3'd4,
    StDropped = 3'd5
  } status_e;

endpackage

### hdl/client_session_table_aging_core.sv
// Channel        | Handshake                 | Payload
// ---------------+---------------------------+-------------------------------------------
// request        | start, busy (always low)  | op_i, client_ip_i, client_port_i, drop_slot_i
// result         | done_o, one-cycle strobe  | status_o, slot_o, active_mask_o, expired_mask_o
// configuration  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A transaction is taken in every cycle and captured in the request register at that edge.
// The slot compare runs from the request register into the result register at the next
// edge, and the result register drives the result ports.
// Reset frees all slots, sets reload_ticks to 10 and clears forwarding_enabled.
// The receiver cannot stall, so the block never holds off a request.
module client_session_table_aging_core import csta_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OpW-1:0]      op_i,
  input  logic [IpW-1:0]      client_ip_i,
  input  logic [PortW-1:0]    client_port_i,
  input  logic [SlotW-1:0]    drop_slot_i,
  output logic                done_o,
  output logic [SlotW-1:0]    status_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [MaskW-1:0]    active_mask_o,
  output logic [MaskW-1:0]    expired_mask_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [TimerW-1:0] reload_q;
  logic              fwd_q;

  logic              req_q;
  logic [OpW-1:0]    op_q;
  logic [IpW-1:0]    ip_q;
  logic [PortW-1:0]  port_q;
  logic [SlotW-1:0]  dslot_q;

  logic [TimerW-1:0] timer_q [NUM_SLOTS];
  logic [TimerW-1:0] timer_d [NUM_SLOTS];
  logic [IpW-1:0]    slot_ip_q [NUM_SLOTS];
  logic [PortW-1:0]  slot_port_q [NUM_SLOTS];

  logic [NUM_SLOTS-1:0] hit;
  logic [NUM_SLOTS-1:0] free;
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] expired;
  logic                 hit_found;
  logic                 free_found;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      free_idx;
  logic [IdxW-1:0]      res_idx;
  logic [IdxW-1:0]      drop_idx;
  logic [31:0]          dslot_wide;
  logic [31:0]          res_wide;
  logic                 drop_ok;
  logic                 add_wr;
  status_e              status_d;

  logic                 done_q;
  logic [SlotW-1:0]     status_q;
  logic [SlotW-1:0]     slot_q;
  logic [MaskW-1:0]     active_q;
  logic [MaskW-1:0]     expired_q;
  logic [MaskW-1:0]     active_d;
  logic [MaskW-1:0]     expired_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= ReloadTicksReset;
      fwd_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgReloadTicks: reload_q <= cfg_data_i;
        CfgFwdEnable:   fwd_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
    end else begin
      req_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      op_q    <= op_i;
      ip_q    <= client_ip_i;
      port_q  <= client_port_i;
      dslot_q <= drop_slot_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free[i] = (timer_q[i] == '0);
      hit[i]  = !free[i] && (slot_ip_q[i] == ip_q) && (slot_port_q[i] == port_q);
    end
  end

  csta_lowest #(
    .N    (NUM_SLOTS),
    .IdxW (IdxW)
  ) u_hit_enc (
    .req_i   (hit),
    .found_o (hit_found),
    .idx_o   (hit_idx)
  );

  csta_lowest #(
    .N    (NUM_SLOTS),
    .IdxW (IdxW)
  ) u_free_enc (
    .req_i   (free),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  assign dslot_wide = 32'(dslot_q);
  assign drop_idx   = dslot_wide[IdxW-1:0];
  assign drop_ok    = (dslot_wide < 32'(NUM_SLOTS));

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      timer_d[i] = timer_q[i];
    end
    expired  = '0;
    add_wr   = 1'b0;
    res_idx  = '0;
    status_d = StIgnored;
    if (req_q) begin
      unique case (op_q)
        OpPacket: begin
          if (fwd_q) begin
            if (hit_found) begin
              timer_d[hit_idx] = reload_q;
              res_idx          = hit_idx;
              status_d         = StKnown;
            end else if (free_found) begin
              timer_d[free_idx] = reload_q;
              add_wr            = 1'b1;
              res_idx           = free_idx;
              status_d          = StAdded;
            end else begin
              status_d = StFull;
            end
          end
        end
        OpTick: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (timer_q[i] != '0) begin
              timer_d[i] = timer_q[i] - TimerW'(1);
              expired[i] = (timer_q[i] == TimerW'(1));
            end
          end
          status_d = StTick;
        end
        OpDrop: begin
          if (drop_ok) begin
            timer_d[drop_idx] = '0;
            res_idx           = drop_idx;
            status_d          = StDropped;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      active[i] = (timer_d[i] != '0);
    end
  end

  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < NUM_SLOTS) begin : g_used
      assign active_d[b]  = active[b];
      assign expired_d[b] = expired[b];
    end else begin : g_unused
      assign active_d[b]  = 1'b0;
      assign expired_d[b] = 1'b0;
    end
  end

  assign res_wide = 32'(res_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        timer_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        timer_q[i] <= timer_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      slot_ip_q[free_idx]   <= ip_q;
      slot_port_q[free_idx] <= port_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_q) begin
      status_q  <= status_d;
      slot_q    <= res_wide[SlotW-1:0];
      active_q  <= active_d;
      expired_q <= expired_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign active_mask_o  = active_q;
  assign expired_mask_o = expired_q;

endmodule

### hdl/csta_lowest.sv
module csta_lowest import csta_pkg::*; #(
  parameter int unsigned N    = NumSlotsDefault,
  parameter int unsigned IdxW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]    req_i,
  output logic            found_o,
  output logic [IdxW-1:0] idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule
